// ----- hw/rtl/pba_pkg.sv -----
// ----------------------------------------------------------------------------
// pba_pkg: page bitmap allocator shared definitions
// Map geometry, field widths, operation and status codes.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int PAGES      = 1024;
  localparam int WORD_BITS  = 32;
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int MAP_WORDS  = (PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PIDX_W     = WORD_IDX_W + BIT_IDX_W;

  localparam int FUNC_W  = 2;
  localparam int PAGE_W  = 10;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 11;
  localparam int CFG_W   = 11;

  typedef logic [WORD_BITS-1:0] map_word_t;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NONE     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_FREE = 2'd2;

  // configuration register indexes
  localparam logic CFG_FIRST_FREE = 1'b0;
  localparam logic CFG_PAGE_COUNT = 1'b1;

endpackage

// ----- hw/rtl/page_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// page_bitmap_allocator: first-fit physical page allocator
//
//   channel  | ports                              | timing
//   ---------+------------------------------------+----------------------------
//   command  | start, busy, func, page            | taken when start & !busy
//   result   | done, page_out, status, free_count | done high for one cycle
//   config   | cfg_we, cfg_index, cfg_data        | written when cfg_we high
//
// Free: result registered in the cycle after the transaction, busy stays low.
// Init: one map word written per cycle, result registered with the last word.
// Alloc: one map word scanned per cycle through the shared word read and
// priority encoder, result when a free page is found or the last word is scanned.
// Reset clears the map and the count directly; no clearing pass.
// The receiver cannot stall; a new command may start in the done cycle.
// ----------------------------------------------------------------------------
module page_bitmap_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [pba_pkg::FUNC_W-1:0]    func,
  input  logic [pba_pkg::PAGE_W-1:0]    page,
  output logic                          done,
  output logic [pba_pkg::PAGE_W-1:0]    page_out,
  output logic [pba_pkg::STAT_W-1:0]    status,
  output logic [pba_pkg::COUNT_W-1:0]   free_count,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [pba_pkg::CFG_W-1:0]     cfg_data
);
  import pba_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(MAP_WORDS - 1);

  logic [1:0]             state;
  logic [WORD_IDX_W-1:0]  scan_idx;
  map_word_t              free_map [MAP_WORDS];
  logic [COUNT_W-1:0]     free_pages;
  logic [CFG_W-1:0]       first_free_page;
  logic [CFG_W-1:0]       page_count;

  logic [COUNT_W-1:0]     limit;
  logic [COUNT_W-1:0]     init_count;
  logic [WORD_IDX_W-1:0]  rd_idx;
  map_word_t              rd_word;
  logic [BIT_IDX_W-1:0]   page_bit;
  logic [BIT_IDX_W-1:0]   low_bit;
  map_word_t              init_mask;
  logic                   free_bad;
  logic [COUNT_W-1:0]     count_dec;
  logic [PIDX_W-1:0]      found_page;

  assign busy = (state != ST_IDLE);

  // clamp page count to the map size
  assign limit = (COUNT_W'(page_count) > COUNT_W'(PAGES)) ? COUNT_W'(PAGES)
                                                          : COUNT_W'(page_count);
  assign init_count = (limit > COUNT_W'(first_free_page))
                      ? limit - COUNT_W'(first_free_page) : '0;

  assign page_bit = page[BIT_IDX_W-1:0];
  assign rd_idx   = busy ? scan_idx : WORD_IDX_W'(page >> BIT_IDX_W);
  assign rd_word  = free_map[rd_idx];

  assign free_bad = (COUNT_W'(page) >= limit) || rd_word[page_bit];

  // lowest set bit of the word under the scan
  always_comb begin
    low_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (rd_word[b]) begin
        low_bit = BIT_IDX_W'(b);
      end
    end
  end

  // bits of the current word that fall in [first_free_page, limit)
  always_comb begin
    logic [PIDX_W:0] p;
    for (int b = 0; b < WORD_BITS; b++) begin
      p = {1'b0, scan_idx, BIT_IDX_W'(b)};
      init_mask[b] = ((PIDX_W+1)'(first_free_page) <= p) &&
                     (p < (PIDX_W+1)'(limit));
    end
  end

  assign count_dec  = (free_pages != '0) ? free_pages - 1'b1 : free_pages;
  assign found_page = {scan_idx, low_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      scan_idx        <= '0;
      done            <= 1'b0;
      free_pages      <= '0;
      first_free_page <= '0;
      page_count      <= CFG_W'(1024);
      for (int w = 0; w < MAP_WORDS; w++) begin
        free_map[w] <= '0;
      end
    end else begin
      done <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST_FREE: first_free_page <= cfg_data;
          CFG_PAGE_COUNT: page_count      <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (start) begin
            case (func)
              FUNC_INIT: begin
                free_pages <= init_count;
                scan_idx   <= '0;
                state      <= ST_INIT;
              end
              FUNC_ALLOC: begin
                scan_idx <= '0;
                state    <= ST_SCAN;
              end
              FUNC_FREE: begin
                done     <= 1'b1;
                page_out <= '0;
                if (free_bad) begin
                  status     <= STAT_BAD_FREE;
                  free_count <= free_pages;
                end else begin
                  free_map[rd_idx][page_bit] <= 1'b1;
                  free_pages <= free_pages + 1'b1;
                  free_count <= free_pages + 1'b1;
                  status     <= STAT_OK;
                end
              end
              default: begin
                done       <= 1'b1;
                page_out   <= '0;
                status     <= STAT_OK;
                free_count <= free_pages;
              end
            endcase
          end
        end

        ST_INIT: begin
          free_map[scan_idx] <= init_mask;
          if (scan_idx == LAST_WORD) begin
            done       <= 1'b1;
            page_out   <= '0;
            status     <= STAT_OK;
            free_count <= free_pages;
            state      <= ST_IDLE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end

        ST_SCAN: begin
          if (rd_word != '0) begin
            // take the lowest free page and drop its bit
            free_map[scan_idx][low_bit] <= 1'b0;
            free_pages <= count_dec;
            done       <= 1'b1;
            page_out   <= PAGE_W'(found_page);
            status     <= STAT_OK;
            free_count <= count_dec;
            state      <= ST_IDLE;
          end else if (scan_idx == LAST_WORD) begin
            done       <= 1'b1;
            page_out   <= '0;
            status     <= STAT_NONE;
            free_count <= free_pages;
            state      <= ST_IDLE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
